FILE: design/fchd_pkg.sv
// shared types, register map and phase codes for the force contact detector
`default_nettype none

package fchd_pkg;

    localparam int unsigned FORCE_W = 16;
    localparam int unsigned MAG_W   = 32;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_UPPER    = 2'd0;
    localparam logic [1:0] REG_LOWER    = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE = 2'd2;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd10;
    localparam logic [CNT_W-1:0] CNT_MAX        = 8'd255;

    // contact phases
    localparam logic [PHASE_W-1:0] PHASE_NONE      = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_GOING     = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ACTIVE    = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_RELEASING = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0] upper_force_sq;
        logic [MAG_W-1:0] lower_force_sq;
        logic [CNT_W-1:0] debounce_count;
    } cfg_t;

endpackage

`default_nettype wire

FILE: design/force_contact_hysteresis_detector.sv
// top level of the force contact detector: pipeline, handshakes and register port
//
// usage
//   input channel (s_valid/s_ready): one force sample per transfer, three signed
//   Q12.4 components. result channel (m_valid/m_ready): one result per sample,
//   the new contact phase (0 none, 1 going, 2 active, 3 releasing) and the
//   in_contact flag (phase active or releasing).
//   configuration goes through the apb port: upper_force_sq at 0x0,
//   lower_force_sq at 0x4, debounce_count at 0x8; pready is tied high.
//   write registers only while no sample is in flight.
//   a sample passes the input register, the magnitude register and the result
//   register, in that order, before its result is presented.
//   throughput: one sample per cycle while m_ready stays high, set by the single
//   magnitude stage and the phase update.
//   reset (aresetn low, synchronous) empties the pipeline, returns the phase to
//   none, clears the debounce counter and loads the register defaults.
//   when the receiver stalls the result holds; the stages behind it keep
//   filling, so up to three samples are taken before s_ready drops.
`default_nettype none

module force_contact_hysteresis_detector (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [fchd_pkg::FORCE_W-1:0] s_force_x,
    input  wire logic signed [fchd_pkg::FORCE_W-1:0] s_force_y,
    input  wire logic signed [fchd_pkg::FORCE_W-1:0] s_force_z,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_in_contact,
    output logic             [fchd_pkg::PHASE_W-1:0] m_contact_phase,
    // configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [fchd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic        [fchd_pkg::DATA_W-1:0]  pwdata,
    output logic             [fchd_pkg::DATA_W-1:0]  prdata,
    output logic                                     pready
);
    import fchd_pkg::*;

    cfg_t cfg;

    // input register stage
    logic                      in_vld_reg;
    logic signed [FORCE_W-1:0] fx_reg;
    logic signed [FORCE_W-1:0] fy_reg;
    logic signed [FORCE_W-1:0] fz_reg;

    // magnitude stage
    logic                      mag_vld_reg;
    logic        [MAG_W-1:0]   mag_reg;
    logic        [MAG_W-1:0]   mag_next;

    // result stage
    logic                      out_vld_reg;
    logic        [PHASE_W-1:0] phase;

    logic load_out;
    logic load_mag;
    logic load_in;

    // each stage moves when the one ahead is empty or moving
    assign load_out = mag_vld_reg && (!out_vld_reg || m_ready);
    assign load_mag = in_vld_reg && (!mag_vld_reg || load_out);
    assign s_ready  = !in_vld_reg || load_mag;
    assign load_in  = s_valid && s_ready;

    fchd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            mag_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (load_in) begin
                in_vld_reg <= 1'b1;
            end else if (load_mag) begin
                in_vld_reg <= 1'b0;
            end
            if (load_mag) begin
                mag_vld_reg <= 1'b1;
            end else if (load_out) begin
                mag_vld_reg <= 1'b0;
            end
            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge aclk) begin
        if (load_in) begin
            fx_reg <= s_force_x;
            fy_reg <= s_force_y;
            fz_reg <= s_force_z;
        end
    end

    fchd_mag u_mag (
        .force_x (fx_reg),
        .force_y (fy_reg),
        .force_z (fz_reg),
        .mag     (mag_next)
    );

    always_ff @(posedge aclk) begin
        if (load_mag) begin
            mag_reg <= mag_next;
        end
    end

    // phase register doubles as the result payload; it only moves on load_out
    fchd_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (load_out),
        .mag     (mag_reg),
        .cfg     (cfg),
        .phase   (phase)
    );

    assign m_valid         = out_vld_reg;
    assign m_contact_phase = phase;
    assign m_in_contact    = phase[1];

endmodule

`default_nettype wire

FILE: design/fchd_regs.sv
// apb configuration registers of the force contact detector
`default_nettype none

module fchd_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fchd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fchd_pkg::DATA_W-1:0] pwdata,
    output logic      [fchd_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output fchd_pkg::cfg_t                  cfg
);
    import fchd_pkg::*;

    logic [MAG_W-1:0] upper_reg;
    logic [MAG_W-1:0] lower_reg;
    logic [CNT_W-1:0] debounce_reg;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg    <= '0;
            lower_reg    <= '0;
            debounce_reg <= DEBOUNCE_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_UPPER:    upper_reg    <= pwdata;
                REG_LOWER:    lower_reg    <= pwdata;
                REG_DEBOUNCE: debounce_reg <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_UPPER:    prdata = upper_reg;
            REG_LOWER:    prdata = lower_reg;
            REG_DEBOUNCE: prdata = {{(DATA_W-CNT_W){1'b0}}, debounce_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.upper_force_sq = upper_reg;
    assign cfg.lower_force_sq = lower_reg;
    assign cfg.debounce_count = debounce_reg;

endmodule

`default_nettype wire

FILE: design/fchd_mag.sv
// squared force magnitude from three signed components
`default_nettype none

module fchd_mag (
    input  wire logic signed [fchd_pkg::FORCE_W-1:0] force_x,
    input  wire logic signed [fchd_pkg::FORCE_W-1:0] force_y,
    input  wire logic signed [fchd_pkg::FORCE_W-1:0] force_z,
    output logic             [fchd_pkg::MAG_W-1:0]   mag
);
    import fchd_pkg::*;

    logic signed [MAG_W-1:0] sq_x;
    logic signed [MAG_W-1:0] sq_y;
    logic signed [MAG_W-1:0] sq_z;

    // each square is at most 2^30, the sum at most 3*2^30, so 32 bits hold it
    assign sq_x = MAG_W'(force_x) * MAG_W'(force_x);
    assign sq_y = MAG_W'(force_y) * MAG_W'(force_y);
    assign sq_z = MAG_W'(force_z) * MAG_W'(force_z);

    assign mag = unsigned'(sq_x) + unsigned'(sq_y) + unsigned'(sq_z);

endmodule

`default_nettype wire

FILE: design/fchd_fsm.sv
// hysteresis and debounce phase machine
`default_nettype none

module fchd_fsm (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  wire logic [fchd_pkg::MAG_W-1:0]   mag,
    input  fchd_pkg::cfg_t                    cfg,
    output logic      [fchd_pkg::PHASE_W-1:0] phase
);
    import fchd_pkg::*;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_bump;
    logic               press;
    logic               release_ok;

    assign press      = mag >= cfg.upper_force_sq;
    assign release_ok = mag <= cfg.lower_force_sq;
    assign cnt_bump   = (cnt_reg == CNT_MAX) ? CNT_MAX : cnt_reg + 1'b1;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PHASE_NONE: begin
                if (press) begin
                    cnt_next   = 8'd1;
                    phase_next = PHASE_GOING;
                end
            end
            PHASE_GOING: begin
                if (!press) begin
                    cnt_next   = '0;
                    phase_next = PHASE_NONE;
                end else if (cnt_bump >= cfg.debounce_count) begin
                    cnt_next   = '0;
                    phase_next = PHASE_ACTIVE;
                end else begin
                    cnt_next   = cnt_bump;
                end
            end
            PHASE_ACTIVE: begin
                if (release_ok) begin
                    cnt_next   = 8'd1;
                    phase_next = PHASE_RELEASING;
                end
            end
            PHASE_RELEASING: begin
                if (!release_ok) begin
                    cnt_next   = '0;
                    phase_next = PHASE_ACTIVE;
                end else if (cnt_bump >= cfg.debounce_count) begin
                    cnt_next   = '0;
                    phase_next = PHASE_NONE;
                end else begin
                    cnt_next   = cnt_bump;
                end
            end
            default: begin
                phase_next = PHASE_NONE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_NONE;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

FILE: design/fchd_checker.sv
// port-level checks of the force contact detector and their bind
`default_nettype none

module fchd_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic                         m_in_contact,
    input wire logic [fchd_pkg::PHASE_W-1:0] m_contact_phase,
    input wire logic                         pready
);
    import fchd_pkg::*;

    // a stalled result keeps its phase
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_contact_phase))
        else $error("result changed while stalled");

    // flag follows the phase
    a_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_in_contact == (m_contact_phase == PHASE_ACTIVE ||
                                      m_contact_phase == PHASE_RELEASING)))
        else $error("contact flag disagrees with phase");

    // reset empties the result stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // with the result stage empty nothing can block the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty result stage");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind force_contact_hysteresis_detector fchd_checker u_fchd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_in_contact    (m_in_contact),
    .m_contact_phase (m_contact_phase),
    .pready          (pready)
);

`default_nettype wire

FILE: tb/force_contact_hysteresis_detector_tb.sv
// self-checking testbench for the force contact hysteresis detector
`timescale 1ns / 1ps

module force_contact_hysteresis_detector_tb;
    import fchd_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // long receiver hold-off used to fill the pipeline
    localparam int unsigned HOLD_CYCLES    = 300;
    // idle cycles after the last result before registers are touched
    localparam int unsigned SETTLE_CYCLES  = 4;

    typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;
    typedef enum {CLS_PRESS, CLS_RELEASE, CLS_MID, CLS_NOISE} sample_class_t;

    typedef struct {
        logic               in_contact;
        logic [PHASE_W-1:0] contact_phase;
        int unsigned        sample_no;
    } contact_result_t;

    // dut connections, all inputs known from time zero
    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic signed [FORCE_W-1:0] s_force_x       = '0;
    logic signed [FORCE_W-1:0] s_force_y       = '0;
    logic signed [FORCE_W-1:0] s_force_z       = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic                      m_in_contact;
    logic [PHASE_W-1:0]        m_contact_phase;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [ADDR_W-1:0]         paddr           = '0;
    logic [DATA_W-1:0]         pwdata          = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // shadow copy of the registers and of the contact tracker
    cfg_t             cfg_shadow    = '{upper_force_sq: '0, lower_force_sq: '0,
                                        debounce_count: DEBOUNCE_RESET};
    logic [PHASE_W-1:0] track_phase = PHASE_NONE;
    logic [CNT_W-1:0]   track_count = '0;

    contact_result_t expected_q[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_req_count = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    int unsigned mismatches     = 0;
    int unsigned samples_sent   = 0;
    int unsigned results_seen   = 0;
    int unsigned config_writes  = 0;
    int unsigned input_stalls   = 0;
    int unsigned idle_cycles    = 0;

    force_contact_hysteresis_detector u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_force_x       (s_force_x),
        .s_force_y       (s_force_y),
        .s_force_z       (s_force_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_in_contact    (m_in_contact),
        .m_contact_phase (m_contact_phase),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // contact prediction
    // ------------------------------------------------------------------

    // exact squared magnitude, at most 3*2^30 so it always fits 32 bits
    function automatic logic [MAG_W-1:0] force_mag_sq(input logic signed [FORCE_W-1:0] fx,
                                                      input logic signed [FORCE_W-1:0] fy,
                                                      input logic signed [FORCE_W-1:0] fz);
        longint sx, sy, sz;
        sx = longint'(fx);
        sy = longint'(fy);
        sz = longint'(fz);
        return MAG_W'(sx * sx + sy * sy + sz * sz);
    endfunction

    // advances the shadow tracker by one sample and returns the new phase
    function automatic contact_result_t predict_contact(input logic signed [FORCE_W-1:0] fx,
                                                        input logic signed [FORCE_W-1:0] fy,
                                                        input logic signed [FORCE_W-1:0] fz);
        contact_result_t  res;
        logic [MAG_W-1:0] mag;
        logic             pressing;
        logic             released;
        logic [PHASE_W-1:0] next_phase;
        mag      = force_mag_sq(fx, fy, fz);
        pressing = (mag >= cfg_shadow.upper_force_sq);
        released = (mag <= cfg_shadow.lower_force_sq);
        next_phase = track_phase;
        case (track_phase)
            PHASE_NONE: begin
                // staying idle leaves the counter alone
                if (pressing) begin
                    track_count = 8'd1;
                    next_phase  = PHASE_GOING;
                end
            end
            PHASE_GOING: begin
                if (pressing) begin
                    // saturating bump, then compare with the current debounce
                    track_count = (track_count == CNT_MAX) ? CNT_MAX : track_count + 8'd1;
                    if (track_count >= cfg_shadow.debounce_count) begin
                        track_count = '0;
                        next_phase  = PHASE_ACTIVE;
                    end
                end else begin
                    track_count = '0;
                    next_phase  = PHASE_NONE;
                end
            end
            PHASE_ACTIVE: begin
                if (released) begin
                    track_count = 8'd1;
                    next_phase  = PHASE_RELEASING;
                end
            end
            default: begin
                if (released) begin
                    track_count = (track_count == CNT_MAX) ? CNT_MAX : track_count + 8'd1;
                    if (track_count >= cfg_shadow.debounce_count) begin
                        track_count = '0;
                        next_phase  = PHASE_NONE;
                    end
                end else begin
                    track_count = '0;
                    next_phase  = PHASE_ACTIVE;
                end
            end
        endcase
        track_phase       = next_phase;
        res.contact_phase = next_phase;
        res.in_contact    = (next_phase == PHASE_ACTIVE) || (next_phase == PHASE_RELEASING);
        res.sample_no     = samples_sent;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // reporting and result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // every result transfer is matched against the oldest expectation
    always @(posedge aclk) begin
        contact_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing expected (phase %0d)",
                                          m_contact_phase));
            end else begin
                want = expected_q.pop_front();
                if (m_contact_phase !== want.contact_phase)
                    report_mismatch($sformatf("sample %0d: contact_phase %0d, want %0d",
                                              want.sample_no, m_contact_phase,
                                              want.contact_phase));
                if (m_in_contact !== want.in_contact)
                    report_mismatch($sformatf("sample %0d: in_contact %0b, want %0b",
                                              want.sample_no, m_in_contact, want.in_contact));
            end
        end
    end

    // receiver: random stalls, plus a long counted hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_req_count) begin
            hold_seen <= hold_req_count;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog: any transfer on any port restarts the count
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready)
            input_stalls++;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** force_contact_hysteresis_detector: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:   begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SOURCE: begin src_idle_pct = 83; sink_stall_pct = 0;  end
            IDLE_SINK:   begin src_idle_pct = 0;  sink_stall_pct = 83; end
            default:     begin src_idle_pct = 6;  sink_stall_pct = 6;  end
        endcase
    endtask

    // one sample transfer; valid is only lowered for a source gap
    task automatic send_sample(input logic signed [FORCE_W-1:0] fx,
                               input logic signed [FORCE_W-1:0] fy,
                               input logic signed [FORCE_W-1:0] fz);
        contact_result_t res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_force_x <= fx;
        s_force_y <= fy;
        s_force_z <= fz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = predict_contact(fx, fy, fz);
        expected_q.push_back(res);
        samples_sent++;
    endtask

    // drop valid and wait until the pipeline has nothing left in flight
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic read_reg(input logic [1:0] idx);
        logic [DATA_W-1:0] want;
        case (idx)
            REG_UPPER: want = cfg_shadow.upper_force_sq;
            REG_LOWER: want = cfg_shadow.lower_force_sq;
            default:   want = DATA_W'(cfg_shadow.debounce_count);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d read 0x%08h, want 0x%08h",
                                      idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // write, update the shadow copy, then read back
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_UPPER: cfg_shadow.upper_force_sq = value;
            REG_LOWER: cfg_shadow.lower_force_sq = value;
            default:   cfg_shadow.debounce_count = value[CNT_W-1:0];
        endcase
        config_writes++;
        read_reg(idx);
    endtask

    task automatic set_thresholds(input logic [MAG_W-1:0] upper, input logic [MAG_W-1:0] lower,
                                  input logic [CNT_W-1:0] debounce);
        wait_idle();
        write_reg(REG_UPPER, upper);
        write_reg(REG_LOWER, lower);
        write_reg(REG_DEBOUNCE, DATA_W'(debounce));
    endtask

    function automatic logic signed [FORCE_W-1:0] rand_comp(input int amp);
        int v;
        v = int'($urandom_range(0, 2 * amp)) - amp;
        if (v > 32767)
            v = 32767;
        return v[FORCE_W-1:0];
    endfunction

    // draws a sample whose magnitude falls in the wanted class; a mid draw can miss
    task automatic pick_sample(input sample_class_t cls,
                               output logic signed [FORCE_W-1:0] fx,
                               output logic signed [FORCE_W-1:0] fy,
                               output logic signed [FORCE_W-1:0] fz);
        logic [MAG_W-1:0] mag;
        int               amp;
        bit               hit;
        fx  = FORCE_W'($urandom);
        fy  = FORCE_W'($urandom);
        fz  = FORCE_W'($urandom);
        hit = (cls == CLS_NOISE);
        // log-spread amplitudes so small and large thresholds are both reachable
        for (int i = 0; i < 64 && !hit; i++) begin
            amp = 1 << $urandom_range(0, 15);
            amp = $urandom_range(0, amp);
            fx  = rand_comp(amp);
            fy  = rand_comp(amp);
            fz  = rand_comp(amp);
            mag = force_mag_sq(fx, fy, fz);
            case (cls)
                CLS_PRESS:   hit = (mag >= cfg_shadow.upper_force_sq);
                CLS_RELEASE: hit = (mag <= cfg_shadow.lower_force_sq);
                default:     hit = (mag > cfg_shadow.lower_force_sq) &&
                                   (mag < cfg_shadow.upper_force_sq);
            endcase
        end
        // fall back to the largest or the zero magnitude
        if (!hit && cls == CLS_PRESS) begin
            fx = 16'sh8000;
            fy = 16'sh8000;
            fz = 16'sh8000;
        end else if (!hit && cls == CLS_RELEASE) begin
            fx = '0;
            fy = '0;
            fz = '0;
        end
    endtask

    // runs of pressing, released, mid or noise samples, mostly around the debounce length
    task automatic run_random_setting(input logic [MAG_W-1:0] upper,
                                      input logic [MAG_W-1:0] lower,
                                      input logic [CNT_W-1:0] debounce,
                                      input idle_mode_t mode, input int quota);
        int            sent;
        int            run_len;
        int unsigned   r;
        sample_class_t cls;
        logic signed [FORCE_W-1:0] fx, fy, fz;
        set_thresholds(upper, lower, debounce);
        set_idle_mode(mode);
        sent = 0;
        while (sent < quota) begin
            r   = $urandom_range(0, 99);
            cls = (r < 40) ? CLS_PRESS : (r < 80) ? CLS_RELEASE : (r < 92) ? CLS_MID : CLS_NOISE;
            if ($urandom_range(0, 9) < 7)
                run_len = int'(debounce) + int'($urandom_range(0, 3)) - 1;
            else
                run_len = $urandom_range(1, 8);
            if (cls == CLS_NOISE)
                run_len = $urandom_range(1, 3);
            if (run_len < 1)
                run_len = 1;
            repeat (run_len) begin
                pick_sample(cls, fx, fy, fz);
                send_sample(fx, fy, fz);
                sent++;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: zero thresholds press everything, debounce ten
    task automatic test_reset_defaults();
        read_reg(REG_UPPER);
        read_reg(REG_LOWER);
        read_reg(REG_DEBOUNCE);
        set_idle_mode(IDLE_NONE);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sd1, -16'sd1, 16'sd0);
    endtask

    // largest magnitude exactly on the upper threshold, debounce one takes two
    task automatic test_threshold_extremes();
        set_thresholds(32'hC000_0000, 32'hBFFF_FFFF, 8'd1);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000, 16'sh7fff);
    endtask

    // zero debounce acts like one; a broken press run falls back to none
    task automatic test_debounce_zero();
        set_thresholds(32'd16, 32'd15, 8'd0);
        send_sample(16'sd4, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd4, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd3);
        send_sample(-16'sd3, 16'sd0, 16'sd0);
        send_sample(16'sd4, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
    endtask

    // debounce rewritten partway through a press run; stays without change
    task automatic test_debounce_change();
        set_thresholds(32'd100, 32'd50, 8'd5);
        send_sample(16'sd0, 16'sd0, 16'sd8);
        send_sample(16'sd10, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd10, 16'sd0);
        send_sample(16'sd6, 16'sd8, 16'sd0);
        wait_idle();
        write_reg(REG_DEBOUNCE, 32'd4);
        send_sample(16'sd0, 16'sd0, -16'sd10);
        send_sample(16'sd0, 16'sd0, 16'sd8);
        send_sample(16'sd5, 16'sd5, 16'sd0);
        send_sample(-16'sd7, 16'sd1, 16'sd0);
        send_sample(16'sd8, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_settings();
        run_random_setting(32'h4000_0000, 32'h1000_0000, 8'd10,  IDLE_NONE,   170);
        run_random_setting(32'h0100_0000, 32'h00F0_0000, 8'd2,   IDLE_SOURCE, 170);
        run_random_setting(32'h0000_1000, 32'h0000_0800, 8'd3,   IDLE_SINK,   170);
        run_random_setting(32'h8000_0000, 32'h8000_0000, 8'd0,   IDLE_BOTH,   170);
        run_random_setting(32'hC000_0000, 32'h0000_0000, 8'd255, IDLE_NONE,   700);
        run_random_setting(32'h0000_0000, 32'h0000_0000, 8'd1,   IDLE_SOURCE, 150);
        run_random_setting(32'h0000_0001, 32'hC000_0000, 8'd4,   IDLE_SINK,   150);
        run_random_setting(32'h0040_0000, 32'h0001_0000, 8'd6,   IDLE_BOTH,   170);
    endtask

    // receiver held off while samples keep coming, so s_ready has to drop
    task automatic test_backpressure();
        logic signed [FORCE_W-1:0] fx, fy, fz;
        set_thresholds(32'h0010_0000, 32'h0000_4000, 8'd3);
        set_idle_mode(IDLE_NONE);
        hold_req_count++;
        repeat (40) begin
            pick_sample(($urandom_range(0, 1) != 0) ? CLS_PRESS : CLS_RELEASE, fx, fy, fz);
            send_sample(fx, fy, fz);
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_threshold_extremes();
        test_debounce_zero();
        test_debounce_change();
        test_random_settings();
        test_backpressure();

        // drain, then give stray results a chance to show up
        wait_idle();
        repeat (8) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        $display("covered %0d samples and %0d results over %0d register writes",
                 samples_sent, results_seen, config_writes);
        $display("idle phases none/source/sink/both, %0d cycles with input held back",
                 input_stalls);
        if (mismatches == 0) begin
            $display("** force_contact_hysteresis_detector: PASSED **");
        end else begin
            $display("** force_contact_hysteresis_detector: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/fchd_pkg.sv
design/fchd_regs.sv
design/fchd_mag.sv
design/fchd_fsm.sv
design/force_contact_hysteresis_detector.sv
design/fchd_checker.sv
tb/force_contact_hysteresis_detector_tb.sv
